// File: rtl/core/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Types, constants and register indexes for the velocity-rescaling thermostat.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SumW     = 48;
  localparam int unsigned CountW   = 16;
  localparam int unsigned DvdW     = 64;
  localparam int unsigned IterW    = 6;

  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_ENERGY = 2'd1;

  localparam logic [31:0]       ScaleOne   = 32'd65536;
  localparam logic [31:0]       ScaleMax   = 32'hFFFF_FFFF;
  localparam logic [SumW-1:0]   SumMax     = {SumW{1'b1}};
  localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};
  localparam logic [IterW-1:0]  DivLast    = 6'd63;
  localparam logic [IterW-1:0]  SqrtLast   = 6'd31;

  typedef struct packed {
    logic        command;
    logic [31:0] step_index;
    logic [31:0] kinetic_energy;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_word_t;

  typedef struct packed {
    logic        rescaled;
    logic [31:0] scale_factor;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic signed [31:0] vel_z_out;
  } out_word_t;

  typedef enum logic [1:0] {
    DIV_MOD = 2'd0,
    DIV_AVG = 2'd1,
    DIV_QUO = 2'd2
  } div_src_e;

  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2
  } comp_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_src_e div_src;
    logic     div_step;
    logic     sqrt_start;
    logic     sqrt_step;
    logic     scale_max;
    logic     scale_root;
    logic     rescale;
    logic     mul_en;
    comp_e    mul_sel;
    logic     sto_en;
    comp_e    sto_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_vel;
    logic div_last;
    logic sqrt_last;
    logic rem_zero;
    logic quo_zero;
  } dp_status_t;

endpackage

// File: rtl/core/velocity_rescale_thermostat.sv
// Velocity word: x, y and z go in turn through the shared multiplier into the result register.
// Step word, no rescale: the remainder divide (step index mod period) gives a nonzero result.
// Step word with rescale: remainder, average and target/average divides, then a square root;
// a zero average skips the last two. A stall only delays a word behind a waiting result.
// One word in flight; the next is taken while a finished result waits in the output register.
// Reset (async, active low): period 1, target 1.0, scale 1.0, sum and count cleared.
// ----------------------------------------------------------------------------
// velocity_rescale_thermostat
// Top level: sequencer plus datapath for fixed-point velocity rescaling.
// ----------------------------------------------------------------------------
module velocity_rescale_thermostat import vrt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  vrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vrt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a word was still in work");

  a_rescale_no_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.rescaled) |->
      (out_data_o.vel_x_out == '0 && out_data_o.vel_y_out == '0 &&
       out_data_o.vel_z_out == '0))
    else $error("rescale result carries velocity data");
`endif

endmodule

// File: rtl/core/vrt_dp.sv
// ----------------------------------------------------------------------------
// vrt_dp
// Datapath: accumulator, shared restoring divider, bit-pair square root,
// shared velocity multiplier with saturation, and the result register.
// ----------------------------------------------------------------------------
module vrt_dp import vrt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_word_t            in_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  output out_word_t           out_data_o
);

  logic [15:0]       period_q;
  logic [31:0]       target_q;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CountW-1:0] count_q, count_d;
  logic [31:0]       scale_q, scale_d;
  logic              rescaled_q, rescaled_d;
  in_word_t          in_q;

  logic [DvdW-1:0]   dvd_q, dvd_d;
  logic [SumW-1:0]   dvs_q, dvs_d;
  logic [SumW-1:0]   rem_q, rem_d;
  logic [IterW-1:0]  iter_q, iter_d;
  logic [SumW:0]     rem_sh;
  logic [SumW:0]     rem_sub;

  logic [DvdW-1:0]   sq_n_q, sq_n_d;
  logic [35:0]       sq_rem_q, sq_rem_d;
  logic [31:0]       sq_root_q, sq_root_d;
  logic [35:0]       sq_sh, sq_trial;

  logic signed [31:0] mul_a;
  logic signed [64:0] prod_q, prod_d;
  logic signed [31:0] sat_val;
  logic signed [31:0] vx_q, vy_q, vz_q;
  out_word_t          out_q;

  logic [SumW:0]     sum_add;
  logic [15:0]       period_eff;

  assign period_eff = (period_q == '0) ? 16'd1 : period_q;
  assign sum_add    = {1'b0, sum_q} + {{(SumW-31){1'b0}}, in_data_i.kinetic_energy};

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 16'd1;
      target_q <= ScaleOne;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_PERIOD: period_q <= cfg_data_i[15:0];
        CFG_TARGET_ENERGY: target_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // accumulator, scale and flag
  always_comb begin
    sum_d      = sum_q;
    count_d    = count_q;
    scale_d    = scale_q;
    rescaled_d = rescaled_q;
    if (cmd_i.load) begin
      rescaled_d = 1'b0;
      if (!in_data_i.command) begin
        sum_d = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
        if (count_q != CountMax) count_d = count_q + 1'b1;
      end
    end
    if (cmd_i.scale_max)  scale_d = ScaleMax;
    if (cmd_i.scale_root) scale_d = sq_root_q;
    if (cmd_i.rescale) begin
      sum_d      = '0;
      count_d    = '0;
      rescaled_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      count_q    <= '0;
      scale_q    <= ScaleOne;
      rescaled_q <= 1'b0;
    end else begin
      sum_q      <= sum_d;
      count_q    <= count_d;
      scale_q    <= scale_d;
      rescaled_q <= rescaled_d;
    end
  end

  // restoring divider, one quotient bit a cycle; quotient shifts into dvd
  assign rem_sh  = {rem_q, dvd_q[DvdW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    iter_d = iter_q;
    if (cmd_i.div_start) begin
      rem_d  = '0;
      iter_d = '0;
      case (cmd_i.div_src)
        DIV_MOD: begin
          dvd_d = {32'd0, in_q.step_index};
          dvs_d = {{(SumW-16){1'b0}}, period_eff};
        end
        DIV_AVG: begin
          dvd_d = {16'd0, sum_q};
          dvs_d = {{(SumW-CountW){1'b0}}, count_q};
        end
        DIV_QUO: begin
          dvd_d = {target_q, 32'd0};
          dvs_d = dvd_q[SumW-1:0];
        end
        default: begin
          dvd_d = dvd_q;
          dvs_d = dvs_q;
        end
      endcase
    end else if (cmd_i.div_step) begin
      iter_d = iter_q + 1'b1;
      if (!rem_sub[SumW]) begin
        rem_d = rem_sub[SumW-1:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[SumW-1:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      end
    end else if (cmd_i.sqrt_start) begin
      iter_d = '0;
    end else if (cmd_i.sqrt_step) begin
      iter_d = iter_q + 1'b1;
    end
  end

  // square root, two radicand bits a cycle
  assign sq_sh    = {sq_rem_q[33:0], sq_n_q[DvdW-1:DvdW-2]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};

  always_comb begin
    sq_n_d    = sq_n_q;
    sq_rem_d  = sq_rem_q;
    sq_root_d = sq_root_q;
    if (cmd_i.sqrt_start) begin
      sq_n_d    = dvd_q;
      sq_rem_d  = '0;
      sq_root_d = '0;
    end else if (cmd_i.sqrt_step) begin
      sq_n_d = {sq_n_q[DvdW-3:0], 2'b00};
      if (sq_sh >= sq_trial) begin
        sq_rem_d  = sq_sh - sq_trial;
        sq_root_d = {sq_root_q[30:0], 1'b1};
      end else begin
        sq_rem_d  = sq_sh;
        sq_root_d = {sq_root_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q     <= dvd_d;
    dvs_q     <= dvs_d;
    rem_q     <= rem_d;
    sq_n_q    <= sq_n_d;
    sq_rem_q  <= sq_rem_d;
    sq_root_q <= sq_root_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) iter_q <= '0;
    else         iter_q <= iter_d;
  end

  // shared multiplier, product registered before saturation
  always_comb begin
    case (cmd_i.mul_sel)
      COMP_X:  mul_a = in_q.vel_x;
      COMP_Y:  mul_a = in_q.vel_y;
      COMP_Z:  mul_a = in_q.vel_z;
      default: mul_a = in_q.vel_x;
    endcase
    prod_d = prod_q;
    if (cmd_i.mul_en) prod_d = mul_a * $signed({1'b0, scale_q});
  end

  // floor(p / 2^16) fits when bits 64..47 all match the sign
  always_comb begin
    if ((&prod_q[64:47]) || !(|prod_q[64:47])) sat_val = prod_q[47:16];
    else if (prod_q[64])                       sat_val = 32'sh8000_0000;
    else                                       sat_val = 32'sh7FFF_FFFF;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      in_q <= in_data_i;
      vx_q <= '0;
      vy_q <= '0;
      vz_q <= '0;
    end else if (cmd_i.sto_en) begin
      case (cmd_i.sto_sel)
        COMP_X:  vx_q <= sat_val;
        COMP_Y:  vy_q <= sat_val;
        COMP_Z:  vz_q <= sat_val;
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.rescaled     <= rescaled_q;
      out_q.scale_factor <= scale_q;
      out_q.vel_x_out    <= vx_q;
      out_q.vel_y_out    <= vy_q;
      out_q.vel_z_out    <= vz_q;
    end
  end

  assign out_data_o         = out_q;
  assign status_o.in_vel    = in_data_i.command;
  assign status_o.div_last  = (iter_q == DivLast);
  assign status_o.sqrt_last = (iter_q == SqrtLast);
  assign status_o.rem_zero  = (rem_q == '0);
  assign status_o.quo_zero  = (dvd_q == '0);

endmodule

// File: rtl/core/vrt_ctrl.sv
// ----------------------------------------------------------------------------
// vrt_ctrl
// Sequencer: handshakes, divide/root ordering and velocity multiply steps.
// ----------------------------------------------------------------------------
module vrt_ctrl import vrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_MOD_LD  = 15'b000000000000010,
    S_MOD_RUN = 15'b000000000000100,
    S_AVG_LD  = 15'b000000000001000,
    S_AVG_RUN = 15'b000000000010000,
    S_QUO_LD  = 15'b000000000100000,
    S_QUO_RUN = 15'b000000001000000,
    S_SQ_LD   = 15'b000000010000000,
    S_SQ_RUN  = 15'b000000100000000,
    S_SQ_END  = 15'b000001000000000,
    S_MX      = 15'b000010000000000,
    S_MY      = 15'b000100000000000,
    S_MZ      = 15'b001000000000000,
    S_MW      = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_vel ? S_MX : S_MOD_LD;
        end
      end
      S_MOD_LD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = DIV_MOD;
        state_d         = S_MOD_RUN;
      end
      S_MOD_RUN: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_AVG_LD;
      end
      S_AVG_LD: begin
        if (!status_i.rem_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DIV_AVG;
          state_d         = S_AVG_RUN;
        end
      end
      S_AVG_RUN: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_QUO_LD;
      end
      S_QUO_LD: begin
        // zero average: scale goes to full range
        if (status_i.quo_zero) begin
          cmd_o.scale_max = 1'b1;
          cmd_o.rescale   = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DIV_QUO;
          state_d         = S_QUO_RUN;
        end
      end
      S_QUO_RUN: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_SQ_LD;
      end
      S_SQ_LD: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQ_RUN;
      end
      S_SQ_RUN: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_last) state_d = S_SQ_END;
      end
      S_SQ_END: begin
        cmd_o.scale_root = 1'b1;
        cmd_o.rescale    = 1'b1;
        state_d          = S_DONE;
      end
      S_MX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = COMP_X;
        state_d       = S_MY;
      end
      S_MY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = COMP_Y;
        cmd_o.sto_en  = 1'b1;
        cmd_o.sto_sel = COMP_X;
        state_d       = S_MZ;
      end
      S_MZ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = COMP_Z;
        cmd_o.sto_en  = 1'b1;
        cmd_o.sto_sel = COMP_Y;
        state_d       = S_MW;
      end
      S_MW: begin
        cmd_o.sto_en  = 1'b1;
        cmd_o.sto_sel = COMP_Z;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load)              out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: tb/velocity_rescale_thermostat_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// velocity_rescale_thermostat_test
// Drives step and velocity words with random gaps and stalls, predicts each
// result from a local thermostat model and checks the results in order.
// ----------------------------------------------------------------------------
module velocity_rescale_thermostat_test;
  import vrt_pkg::*;

  localparam int unsigned CycleLimit = 1500000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_word_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  int unsigned hold_off = 0;

  velocity_rescale_thermostat uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  class thermostat_board;
    logic [15:0]  period;
    logic [31:0]  target;
    logic [47:0]  sum;
    logic [15:0]  count;
    logic [31:0]  scale;
    out_word_t    pending[$];

    function new();
      period = 16'd1;
      target = ScaleOne;
      sum    = '0;
      count  = '0;
      scale  = ScaleOne;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
      if (idx == CFG_SAMPLE_PERIOD) period = val[15:0];
      else if (idx == CFG_TARGET_ENERGY) target = val;
    endfunction

    function logic [63:0] root64(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic signed [31:0] mul_sat(logic signed [31:0] v, logic [31:0] s);
      logic signed [63:0] p, q;
      p = 64'(v) * $signed({32'd0, s});
      q = p >>> 16;
      if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (q < -64'sd2147483648) return 32'h8000_0000;
      return q[31:0];
    endfunction

    function void note_input(in_word_t w);
      out_word_t   r;
      logic [31:0] per;
      logic [48:0] acc;
      logic [63:0] avg, quo, rt;
      r = '0;
      if (!w.command) begin
        per = (period == 16'd0) ? 32'd1 : {16'd0, period};
        if (count != CountMax) count++;
        acc = {1'b0, sum} + {17'd0, w.kinetic_energy};
        sum = acc[48] ? SumMax : acc[47:0];
        if (w.step_index % per == 32'd0) begin
          avg = {16'd0, sum} / {48'd0, count};
          if (avg == 64'd0) begin
            scale = ScaleMax;
          end else begin
            quo = {target, 32'd0} / avg;
            rt = root64(quo);
            scale = (rt > 64'hFFFF_FFFF) ? ScaleMax : rt[31:0];
          end
          sum = '0;
          count = '0;
          r.rescaled = 1'b1;
        end
      end else begin
        r.vel_x_out = mul_sat(w.vel_x, scale);
        r.vel_y_out = mul_sat(w.vel_y, scale);
        r.vel_z_out = mul_sat(w.vel_z, scale);
      end
      r.scale_factor = scale;
      pending.push_back(r);
    endfunction

    task check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report("unexpected word", got.scale_factor, '0);
        return;
      end
      want = pending.pop_front();
      if (got.rescaled !== want.rescaled)
        report("rescaled", {31'd0, got.rescaled}, {31'd0, want.rescaled});
      if (got.scale_factor !== want.scale_factor)
        report("scale_factor", got.scale_factor, want.scale_factor);
      if (got.vel_x_out !== want.vel_x_out) report("vel_x_out", got.vel_x_out, want.vel_x_out);
      if (got.vel_y_out !== want.vel_y_out) report("vel_y_out", got.vel_y_out, want.vel_y_out);
      if (got.vel_z_out !== want.vel_z_out) report("vel_z_out", got.vel_z_out, want.vel_z_out);
    endtask
  endclass

  thermostat_board board = new();

  // accepted words and delivered results seen at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[velocity_rescale_thermostat] ERROR");
      $finish;
    end
  end

  // receiver stall, with a counted long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off != 0) begin
      hold_off--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 31);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
  endtask

  task automatic send(input in_word_t w);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 31) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_step(input logic [31:0] step, input logic [31:0] ke);
    in_word_t w;
    w = '0;
    w.command = 1'b0;
    w.step_index = step;
    w.kinetic_energy = ke;
    w.vel_x = $urandom();
    w.vel_y = $urandom();
    w.vel_z = $urandom();
    send(w);
  endtask

  task automatic send_vel(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    in_word_t w;
    w = '0;
    w.command = 1'b1;
    w.step_index = $urandom();
    w.kinetic_energy = $urandom();
    w.vel_x = x;
    w.vel_y = y;
    w.vel_z = z;
    send(w);
  endtask

  function automatic logic [31:0] rand_ke();
    case ($urandom_range(3))
      0: return $urandom_range(65535);
      1: return $urandom();
      2: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(1 << 20, 1 << 24);
    endcase
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'h8000_0000 + $urandom_range(3);
      default: return $signed($urandom_range(1 << 20)) - (1 << 19);
    endcase
  endfunction

  initial begin
    logic [15:0] per;
    logic [31:0] step;
    int unsigned n;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: identity scale, extremes, zero average, zero period
    send_vel(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_step(32'd0, 32'd0);
    send_vel(32'h0001_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    send_step(32'd3, 32'hFFFF_FFFF);
    send_vel(32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0000_0001);
    drain();
    write_reg(CFG_TARGET_ENERGY, 32'hFFFF_FFFF);
    write_reg(CFG_SAMPLE_PERIOD, 32'd0);
    send_step(32'd7, 32'd1);
    send_vel(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF);
    send_step(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    write_reg(CFG_TARGET_ENERGY, 32'd0);
    write_reg(CFG_SAMPLE_PERIOD, 32'h0000_FFFF);
    send_step(32'd1, 32'hFFFF_FFFF);
    send_step(32'd2, 32'hFFFF_FFFF);
    send_step(32'd65535, 32'd5);
    send_vel(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    drain();
    write_reg(2'd2, 32'hFFFF_FFFF); // unused index, ignored
    write_reg(2'd3, 32'd0);
    write_reg(CFG_TARGET_ENERGY, ScaleOne);
    write_reg(CFG_SAMPLE_PERIOD, 32'd4);

    // random phases: mostly velocity words, with step words mixed in
    n = 0;
    step = 0;
    while (n < 1700) begin
      if (n % 300 == 0 && n != 0) begin
        drain();
        per = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 8));
        write_reg(CFG_SAMPLE_PERIOD, {16'd0, per});
        write_reg(CFG_TARGET_ENERGY, ($urandom_range(2) == 0) ? $urandom() :
                  $urandom_range(1 << 14, 1 << 20));
        step = $urandom_range(1) ? $urandom() : 0;
      end
      if (n == 600) calm = 1'b1;
      if (n == 800) calm = 1'b0;
      if (n == 1000) hold_off = 400;
      if (n == 1200) drain();
      if ($urandom_range(99) < 25) begin
        send_step($urandom_range(9) == 0 ? $urandom() : step, rand_ke());
        step++;
      end else begin
        send_vel(rand_vel(), rand_vel(), rand_vel());
      end
      n++;
    end
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
    if (errors == 0) $display("[velocity_rescale_thermostat] OK");
    else $display("[velocity_rescale_thermostat] ERROR");
    $finish;
  end
endmodule
